FILE: hw/rtl/aabbfc_pkg.sv
// Shared types, constants and the rotated plane search for the box cull block.
package aabbfc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_IDX_W = 3;
  localparam int NORM_W      = 16;
  localparam int CFG_W       = 64;
  // w is Q8.8, normals Q1.14: -2w at the product scale is -w shifted by 15
  localparam int BOUND_SHIFT = 15;

  // One packed plane register: w in the top field, then nz, ny, nx
  typedef struct packed {
    logic signed [NORM_W-1:0] w;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  // Stage load enables handed to each plane lane
  typedef struct packed {
    logic en2;
    logic en3;
  } pipe_ctl_t;

  typedef struct packed {
    logic                   culled;
    logic [PLANE_IDX_W-1:0] plane;
  } cull_res_t;

  // Pick the first culling plane in the order start, start+1, ... (mod 6)
  function automatic cull_res_t first_cull(input logic [PLANE_COUNT-1:0]  cull,
                                           input logic [PLANE_IDX_W-1:0] start);
    cull_res_t              res;
    logic [PLANE_IDX_W-1:0] s;
    logic [PLANE_IDX_W:0]   idx;
    res = '0;
    s = (start >= PLANE_IDX_W'(PLANE_COUNT)) ? start - PLANE_IDX_W'(PLANE_COUNT) : start;
    // walk from the last step down so the earliest step wins
    for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
      idx = {1'b0, s} + (PLANE_IDX_W + 1)'(i);
      if (idx >= (PLANE_IDX_W + 1)'(PLANE_COUNT)) begin
        idx = idx - (PLANE_IDX_W + 1)'(PLANE_COUNT);
      end
      if (cull[idx[PLANE_IDX_W-1:0]]) begin
        res.culled = 1'b1;
        res.plane  = idx[PLANE_IDX_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/aabbfc_planes.sv
// Plane register file written through the configuration port.
module aabbfc_planes (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [aabbfc_pkg::PLANE_IDX_W-1:0]   cfg_index,
  input  logic [aabbfc_pkg::CFG_W-1:0]         cfg_data,
  output aabbfc_pkg::plane_t                   planes [aabbfc_pkg::PLANE_COUNT]
);
  import aabbfc_pkg::*;

  plane_t plane_reg [PLANE_COUNT];

  // Hold planes; drop writes to indexes beyond the last plane
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < PLANE_IDX_W'(PLANE_COUNT))) begin
      plane_reg[cfg_index] <= plane_t'(cfg_data);
    end
  end

  assign planes = plane_reg;

endmodule

FILE: hw/rtl/aabbfc_lane.sv
// One plane lane: registered products, then a registered cull bit from the sum and bound compare.
module aabbfc_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  aabbfc_pkg::pipe_ctl_t             ctl,
  input  aabbfc_pkg::plane_t                plane,
  input  logic signed [COORD_WIDTH:0]       center [3],
  input  logic signed [COORD_WIDTH:0]       extent [3],
  output logic                              cull
);
  import aabbfc_pkg::*;

  localparam int EXT_W  = COORD_WIDTH + 1;
  localparam int PROD_W = EXT_W + NORM_W + 1;
  localparam int ACC_W  = (PROD_W + 3 > 2 * NORM_W + 1) ? PROD_W + 3 : 2 * NORM_W + 1;

  logic signed [PROD_W-1:0] n_wide   [3];
  logic signed [PROD_W-1:0] nmag     [3];
  logic signed [PROD_W-1:0] c_wide   [3];
  logic signed [PROD_W-1:0] e_wide   [3];
  logic signed [PROD_W-1:0] d_prod   [3];
  logic signed [PROD_W-1:0] r_prod   [3];
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  w_wide;
  logic signed [ACC_W-1:0]  bound;

  // Widen operands and take the normal magnitudes
  always_comb begin
    n_wide[0] = PROD_W'(plane.nx);
    n_wide[1] = PROD_W'(plane.ny);
    n_wide[2] = PROD_W'(plane.nz);
    for (int a = 0; a < 3; a++) begin
      nmag[a]   = n_wide[a][PROD_W-1] ? -n_wide[a] : n_wide[a];
      c_wide[a] = PROD_W'(center[a]);
      e_wide[a] = PROD_W'(extent[a]);
    end
  end

  // Stage two: register the six products of this plane
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      for (int a = 0; a < 3; a++) begin
        d_prod[a] <= c_wide[a] * n_wide[a];
        r_prod[a] <= e_wide[a] * nmag[a];
      end
    end
  end

  // Add d and r and compare against -2w at the product scale
  always_comb begin
    sum = '0;
    for (int a = 0; a < 3; a++) begin
      sum = sum + ACC_W'(d_prod[a]) + ACC_W'(r_prod[a]);
    end
    w_wide = ACC_W'(plane.w);
    bound  = -(w_wide <<< BOUND_SHIFT);
  end

  // Stage three: register the cull decision
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      cull <= (sum < bound);
    end
  end

endmodule

FILE: hw/rtl/aabb_frustum_cull.sv
// Top level: box against six frustum planes, four-stage pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall  | min_x..max_z, start_plane
//  out     | from block| out_valid / out_stall| culled, culling_plane
//  cfg     | to block  | cfg_we               | cfg_index, cfg_data (plane 0..5)
//
// One box enters per cycle while in_stall is low; its result moves stage by stage.
// Stages: centre/extent, per-plane products, per-plane sum and compare, rotated
// priority pick into the output register. Each stage has its own valid bit and
// loads whenever the next stage is empty or moving, so bubbles close up under
// out_stall. Reset clears the valid bits and the six plane registers to zero.
module aabb_frustum_cull #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       min_x,
  input  logic signed [COORD_WIDTH-1:0]       min_y,
  input  logic signed [COORD_WIDTH-1:0]       min_z,
  input  logic signed [COORD_WIDTH-1:0]       max_x,
  input  logic signed [COORD_WIDTH-1:0]       max_y,
  input  logic signed [COORD_WIDTH-1:0]       max_z,
  input  logic [aabbfc_pkg::PLANE_IDX_W-1:0]  start_plane,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                culled,
  output logic [aabbfc_pkg::PLANE_IDX_W-1:0]  culling_plane,
  input  logic                                cfg_we,
  input  logic [aabbfc_pkg::PLANE_IDX_W-1:0]  cfg_index,
  input  logic [aabbfc_pkg::CFG_W-1:0]        cfg_data
);
  import aabbfc_pkg::*;

  localparam int EXT_W = COORD_WIDTH + 1;

  plane_t                  planes [PLANE_COUNT];
  pipe_ctl_t               ctl;
  logic                    v1, v2, v3, v4;
  logic                    en1, en4;
  logic signed [EXT_W-1:0] center [3];
  logic signed [EXT_W-1:0] extent [3];
  logic [PLANE_IDX_W-1:0]  start1, start2, start3;
  logic [PLANE_COUNT-1:0]  cull3;
  cull_res_t               pick;

  aabbfc_planes u_planes (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // Advance each stage when the one after it is empty or moving
  always_comb begin
    en4      = !v4 || !out_stall;
    ctl.en3  = !v3 || en4;
    ctl.en2  = !v2 || ctl.en3;
    en1      = !v1 || ctl.en2;
    in_stall = !en1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1)     v1 <= in_valid;
      if (ctl.en2) v2 <= v1;
      if (ctl.en3) v3 <= v2;
      if (en4)     v4 <= v3;
    end
  end

  // Stage one: centre and extent, exact at one extra bit
  always_ff @(posedge clk) begin
    if (en1) begin
      center[0] <= EXT_W'(min_x) + EXT_W'(max_x);
      center[1] <= EXT_W'(min_y) + EXT_W'(max_y);
      center[2] <= EXT_W'(min_z) + EXT_W'(max_z);
      extent[0] <= EXT_W'(max_x) - EXT_W'(min_x);
      extent[1] <= EXT_W'(max_y) - EXT_W'(min_y);
      extent[2] <= EXT_W'(max_z) - EXT_W'(min_z);
      start1    <= start_plane;
    end
  end

  // Carry the start plane alongside the lanes
  always_ff @(posedge clk) begin
    if (ctl.en2) start2 <= start1;
    if (ctl.en3) start3 <= start2;
  end

  // Stages two and three: one lane per plane
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    aabbfc_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .plane  (planes[p]),
      .center (center),
      .extent (extent),
      .cull   (cull3[p])
    );
  end

  // Stage four: pick the first culling plane in rotated order
  assign pick = first_cull(cull3, start3);

  always_ff @(posedge clk) begin
    if (en4) begin
      culled        <= pick.culled;
      culling_plane <= pick.plane;
    end
  end

  assign out_valid = v4;

endmodule
